>>> sv/lca_pkg.sv
package lca_pkg;

  // Port field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 5;
  localparam int SIZE_W = 6;
  localparam int GEN_W  = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd20;

  // B3/S23 thresholds
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Next state of one cell from its eight neighbours
  function automatic logic cell_next(input logic [7:0] nb, input logic live);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(nb[i]);
    end
    return (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_LOW) && live);
  endfunction

endpackage

>>> sv/lca_row_next.sv
// One generation for a whole row from a three-row window; no wrap at the edges.
module lca_row_next
  import lca_pkg::*;
#(
  parameter int W = 32
) (
  input  logic [W-1:0] up,
  input  logic [W-1:0] mid,
  input  logic [W-1:0] dn,
  input  logic [W-1:0] span,
  output logic [W-1:0] nxt
);

  logic [W+1:0] up_x;
  logic [W+1:0] mid_x;
  logic [W+1:0] dn_x;

  // zero guard column on each side
  assign up_x  = {1'b0, up,  1'b0};
  assign mid_x = {1'b0, mid, 1'b0};
  assign dn_x  = {1'b0, dn,  1'b0};

  for (genvar c = 0; c < W; c++) begin : g_col
    logic [7:0] nb;
    assign nb = {up_x[c], up_x[c+1], up_x[c+2],
                 mid_x[c],           mid_x[c+2],
                 dn_x[c], dn_x[c+1], dn_x[c+2]};
    // columns beyond the size in use stay dead
    assign nxt[c] = span[c] & cell_next(nb, mid[c]);
  end

endmodule

>>> sv/life_cellular_automaton_grid.sv
// Game of Life grid, rule B3/S23, with one-bit cells held one row to a memory
// word. Pulse start with op, row, column and alive while busy is low; the item
// is taken on that edge. Every item gives exactly one result: done is high for
// a single cycle with cell_alive and generation, and the receiver must take it
// then, as there is no way to hold it off. Write and read raise done from
// S_CELL, clear from idle. A step reads the n rows in use (n being min of
// grid_size and GRID_SIZE) and one dead row below them: the step sweeps the
// grid one row per cycle through a three-row window, bound by the single read
// port of the row memory. A new item can be taken in the cycle that done is
// high. Writing grid_size (cfg_valid/cfg_ready, only while idle) starts a
// sweep over the rows in use that kills every cell outside the new size; busy
// stays high during it. Reset leaves all cells dead and needs no clearing
// pass: each row carries a valid bit, and a row not yet written reads as dead.
module life_cellular_automaton_grid
  import lca_pkg::*;
#(
  parameter int GRID_SIZE = 32
) (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op,
  input  logic [IDX_W-1:0]  row,
  input  logic [IDX_W-1:0]  column,
  input  logic              alive,
  // result channel
  output logic              done,
  output logic              cell_alive,
  output logic [GEN_W-1:0]  generation,
  // grid_size register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int RW = $clog2(GRID_SIZE);       // row / column address
  localparam int CW = $clog2(GRID_SIZE + 1);   // counts up to the size itself
  localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CELL = 4'b0010,   // read-modify-write of one row for write / read
    S_STEP = 4'b0100,   // generation sweep
    S_SIZE = 4'b1000    // trim sweep after a size change
  } state_t;

  state_t                state;
  logic [SIZE_W-1:0]     grid_size;
  logic [GEN_W-1:0]      gen_count;
  logic [GRID_SIZE-1:0]  row_valid;

  // row memory: one word per grid row, bit c is column c
  logic [GRID_SIZE-1:0]  mem [GRID_SIZE];
  logic [GRID_SIZE-1:0]  rdata;
  logic                  rd_ok;

  // sweep control
  logic [CW-1:0]         iss;       // next row to read
  logic                  iss_done;
  logic                  rd_pend;   // rdata belongs to row rd_idx
  logic [CW-1:0]         rd_idx;
  logic [GRID_SIZE-1:0]  up;
  logic [GRID_SIZE-1:0]  mid;

  // captured item
  logic                  op_wr;
  logic [RW-1:0]         row_q;
  logic [RW-1:0]         col_q;
  logic                  alive_q;
  logic                  inside_q;
  logic                  cell_q;

  // memory port controls
  logic                  rd_en;
  logic                  rd_gate;
  logic [RW-1:0]         raddr;
  logic                  we;
  logic [RW-1:0]         waddr;
  logic [GRID_SIZE-1:0]  wdata;

  logic [CW-1:0]         n_use;
  logic [GRID_SIZE-1:0]  span_mask;
  logic [GRID_SIZE-1:0]  cur;
  logic [GRID_SIZE-1:0]  row_new;
  logic                  in_grid;
  logic                  accept;
  logic                  cfg_wr;
  logic [SW-1:0]         gs_ext;

  // size in use, limited to what the memory holds
  assign gs_ext = SW'(grid_size);
  assign n_use  = (gs_ext < SW'(GRID_SIZE)) ? CW'(gs_ext) : CW'(GRID_SIZE);

  // rows and columns below the size in use; the grid is square
  for (genvar i = 0; i < GRID_SIZE; i++) begin : g_span
    assign span_mask[i] = (i < int'(n_use));
  end

  assign in_grid = (SW'(row) < SW'(n_use)) && (SW'(column) < SW'(n_use));

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = (state == S_IDLE) && !start;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // a row never written since reset, clear or trim reads as dead
  assign cur = rd_ok ? rdata : '0;

  lca_row_next #(
    .W (GRID_SIZE)
  ) u_row_next (
    .up   (up),
    .mid  (mid),
    .dn   (cur),
    .span (span_mask),
    .nxt  (row_new)
  );

  // Port steering. During a sweep the read runs ahead of the write (two rows in
  // a step, one row in a trim), so the two never meet on the same word.
  always_comb begin
    rd_en   = 1'b0;
    rd_gate = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && ((op_t'(op) == OP_WRITE) || (op_t'(op) == OP_READ))) begin
          rd_en   = 1'b1;
          rd_gate = in_grid;
          raddr   = RW'(row);
        end
      end
      S_CELL: begin
        if (op_wr && inside_q) begin
          we           = 1'b1;
          waddr        = row_q;
          wdata        = cur;
          wdata[col_q] = alive_q;
        end
      end
      S_STEP: begin
        // one extra read past the last row feeds the dead row below it
        if (!iss_done) begin
          rd_en   = 1'b1;
          rd_gate = (iss < n_use);
          raddr   = RW'(iss);
        end
        if (rd_pend && (rd_idx != '0)) begin
          we    = 1'b1;
          waddr = RW'(rd_idx - 1'b1);
          wdata = row_new;
        end
      end
      S_SIZE: begin
        if (iss < n_use) begin
          rd_en   = 1'b1;
          rd_gate = 1'b1;
          raddr   = RW'(iss);
        end
        if (rd_pend) begin
          we    = 1'b1;
          waddr = RW'(rd_idx);
          wdata = cur & span_mask;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // row memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      grid_size <= SIZE_RESET;
      gen_count <= '0;
      row_valid <= '0;
      done      <= 1'b0;
      cell_q    <= 1'b0;
      rd_ok     <= 1'b0;
      iss       <= '0;
      iss_done  <= 1'b0;
      rd_pend   <= 1'b0;
      rd_idx    <= '0;
      up        <= '0;
      mid       <= '0;
      op_wr     <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      alive_q   <= 1'b0;
      inside_q  <= 1'b0;
    end else begin
      done  <= 1'b0;
      rd_ok <= rd_en && rd_gate && row_valid[raddr];
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_wr    <= (op_t'(op) == OP_WRITE);
            row_q    <= RW'(row);
            col_q    <= RW'(column);
            alive_q  <= alive;
            inside_q <= in_grid;
            unique case (op_t'(op))
              OP_WRITE, OP_READ: begin
                state <= S_CELL;
              end
              OP_STEP: begin
                state    <= S_STEP;
                iss      <= '0;
                iss_done <= 1'b0;
                rd_pend  <= 1'b0;
                up       <= '0;
                mid      <= '0;
              end
              OP_CLEAR: begin
                // dropping every valid bit empties the grid without a sweep
                row_valid <= '0;
                gen_count <= '0;
                cell_q    <= 1'b0;
                done      <= 1'b1;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end else if (cfg_wr) begin
            grid_size <= cfg_data;
            state     <= S_SIZE;
            iss       <= '0;
            rd_pend   <= 1'b0;
          end
        end
        S_CELL: begin
          // outside the size a write is dropped and both ops return dead
          cell_q <= inside_q & (op_wr ? alive_q : cur[col_q]);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_STEP: begin
          if (!iss_done) begin
            iss      <= iss + 1'b1;
            iss_done <= (iss == n_use);
          end
          rd_pend <= !iss_done;
          rd_idx  <= iss;
          if (rd_pend) begin
            // slide the window down one row
            up  <= mid;
            mid <= cur;
            if (rd_idx == n_use) begin
              gen_count <= gen_count + 1'b1;
              cell_q    <= 1'b0;
              done      <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_SIZE: begin
          if (iss < n_use) begin
            iss <= iss + 1'b1;
          end
          rd_pend <= (iss < n_use);
          rd_idx  <= iss;
          if (!(iss < n_use) && !rd_pend) begin
            // rows at or past the new size become dead
            row_valid <= row_valid & span_mask;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cell_alive = cell_q;
  assign generation = gen_count;

  // a sweep never writes the word it is reading in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && rd_en) |-> (waddr != raddr))
    else $error("row memory read and write hit the same word");

  // nothing is ever written outside the size in use
  a_write_in_span: assert property (@(posedge clk) disable iff (rst)
    we |-> (SW'(waddr) < SW'(n_use)))
    else $error("row write outside the size in use");

  // the generation count only moves with a result beat
  a_gen_with_done: assert property (@(posedge clk) disable iff (rst)
    !$stable(gen_count) |-> done)
    else $error("generation changed without a result");

  // a result beat always leaves the block ready for the next item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

endmodule

>>> tb/life_cellular_automaton_grid_tb.sv
module life_cellular_automaton_grid_tb;
  import lca_pkg::*;

  // Tracks the grid the block should hold and the result beats it owes.
  class life_grid_tracker;
    typedef struct {
      logic             cell_bit;
      logic [GEN_W-1:0] gen;
    } outcome_t;

    logic [31:0]       cells [32];
    logic [GEN_W-1:0]  gen;
    logic [SIZE_W-1:0] size_reg;
    outcome_t          owed [$];
    int                failures;

    function new();
      foreach (cells[i]) cells[i] = '0;
      gen      = '0;
      size_reg = SIZE_RESET;
      failures = 0;
    endfunction

    function int span();
      return (size_reg < 32) ? int'(size_reg) : 32;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // New size kills everything outside it; generation is kept.
    function void write_size(logic [SIZE_W-1:0] v);
      int n;
      size_reg = v;
      n = span();
      for (int r = 0; r < 32; r++)
        for (int c = 0; c < 32; c++)
          if (r >= n || c >= n) cells[r][c] = 1'b0;
    endfunction

    function void next_generation();
      logic [31:0] nxt [32];
      int n, cnt, rr, cc;
      n = span();
      foreach (nxt[i]) nxt[i] = '0;
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          cnt = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r + dr;
              cc = c + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < n && cc < n)
                cnt += int'(cells[rr][cc]);
            end
          end
          nxt[r][c] = (cnt == 3) || (cnt == 2 && cells[r][c]);
        end
      end
      cells = nxt;
      gen   = gen + 1'b1;
    endfunction

    function void take_item(op_t o, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c, logic a);
      outcome_t res;
      bit       in_grid;
      in_grid      = (int'(r) < span()) && (int'(c) < span());
      res.cell_bit = 1'b0;
      case (o)
        OP_WRITE: if (in_grid) begin
          cells[r][c]  = a;
          res.cell_bit = a;
        end
        OP_STEP:  next_generation();
        OP_READ:  if (in_grid) res.cell_bit = cells[r][c];
        default: begin
          foreach (cells[i]) cells[i] = '0;
          gen = '0;
        end
      endcase
      res.gen = gen;
      owed.push_back(res);
    endfunction

    function void match_result(logic cell_bit, logic [GEN_W-1:0] g);
      outcome_t want;
      if (owed.size() == 0) begin
        $error("result beat with no item outstanding");
        failures++;
        return;
      end
      want = owed.pop_front();
      if (cell_bit !== want.cell_bit) begin
        $error("cell_alive: expected %0d, actual %0d", want.cell_bit, cell_bit);
        failures++;
      end
      if (g !== want.gen) begin
        $error("generation: expected %0d, actual %0d", want.gen, g);
        failures++;
      end
    endfunction
  endclass

  // DUT-facing signals; every input known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   op        = '0;
  logic [IDX_W-1:0]  row       = '0;
  logic [IDX_W-1:0]  column    = '0;
  logic              alive     = 1'b0;
  logic              done;
  logic              cell_alive;
  logic [GEN_W-1:0]  generation;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  life_grid_tracker grid = new();
  int               items_sent = 0;
  bit               no_idle    = 1'b0;

  life_cellular_automaton_grid #(.GRID_SIZE(32)) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .row        (row),
    .column     (column),
    .alive      (alive),
    .done       (done),
    .cell_alive (cell_alive),
    .generation (generation),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1500000;
    $display("life_cellular_automaton_grid test failed");
    $finish;
  end

  // Monitor. Values read here are the ones settled before the edge, so the
  // DUT's own updates at this edge cannot leak in. The result check runs
  // before the new item is noted: a fresh beat may be taken in the very
  // cycle that done is up, and done always belongs to an older item.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) grid.match_result(cell_alive, generation);
      if (cfg_valid && cfg_ready) grid.write_size(cfg_data);
      if (start && !busy) grid.take_item(op_t'(op), row, column, alive);
    end
  end

  // One item beat. An idle gap may precede it; otherwise start stays high
  // straight on from the previous beat, so it is never lowered and raised
  // in the same step.
  task automatic send_item(op_t o, int r, int c, bit a);
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start  <= 1'b1;
    op     <= o;
    row    <= IDX_W'(r);
    column <= IDX_W'(c);
    alive  <= a;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Hold the sender until every owed result beat is in, then let the clock
  // run on so the block is truly idle. The wait begins with a clock edge,
  // so the beat just taken is already on the owed list.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (grid.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(int v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= SIZE_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly land inside the live area so writes and reads bite.
  function automatic int pick_index(int n);
    if (n > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, 31);
  endfunction

  initial begin
    int sel, n, phase, phase_left;
    int edge_sizes [7];

    edge_sizes = '{2, 32, 0, 1, 63, 33, 5};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset size 20, corners, out-of-range addresses, a blinker,
    // a corner birth, ignored alive bits and a clear.
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_WRITE, 19, 19, 1'b1);
    send_item(OP_WRITE, 31, 31, 1'b1);   // outside: ignored
    send_item(OP_WRITE, 20, 3, 1'b1);    // outside on row only
    send_item(OP_READ, 0, 0, 1'b0);
    send_item(OP_READ, 19, 19, 1'b0);
    send_item(OP_READ, 31, 31, 1'b1);
    send_item(OP_WRITE, 0, 0, 1'b0);
    send_item(OP_WRITE, 5, 4, 1'b1);
    send_item(OP_WRITE, 5, 5, 1'b1);
    send_item(OP_WRITE, 5, 6, 1'b1);
    send_item(OP_WRITE, 18, 19, 1'b1);
    send_item(OP_WRITE, 19, 18, 1'b1);
    send_item(OP_STEP, 31, 31, 1'b1);
    send_item(OP_READ, 4, 5, 1'b0);
    send_item(OP_READ, 6, 5, 1'b0);
    send_item(OP_READ, 5, 4, 1'b0);
    send_item(OP_READ, 18, 18, 1'b0);    // born in the far corner
    send_item(OP_STEP, 0, 0, 1'b0);
    send_item(OP_READ, 5, 4, 1'b1);
    send_item(OP_READ, 31, 0, 1'b1);
    send_item(OP_CLEAR, 31, 31, 1'b1);
    send_item(OP_READ, 5, 5, 1'b0);

    // Random phases, each opened on an idle block with a new size: the
    // extremes and out-of-spec sizes first, small grids mostly after that.
    phase      = 0;
    phase_left = 0;
    n          = 20;
    while (items_sent < 1300) begin
      if (phase_left == 0) begin
        if (phase < 7) n = edge_sizes[phase];
        else begin
          sel = $urandom_range(0, 99);
          if (sel < 70)      n = $urandom_range(2, 10);
          else if (sel < 85) n = $urandom_range(11, 32);
          else               n = $urandom_range(0, 63);
        end
        set_size(n);
        phase++;
        phase_left = $urandom_range(60, 150);
      end
      // a long stretch with the sender never idling
      no_idle = (items_sent >= 500 && items_sent < 800);
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_item(OP_WRITE, pick_index(n), pick_index(n), $urandom_range(0, 99) < 55);
      else if (sel < 72)
        send_item(OP_READ, pick_index(n), pick_index(n), $urandom_range(0, 1));
      else if (sel < 96)
        send_item(OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      else
        send_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      phase_left--;
    end

    // Wind down: every owed beat in, then a full step's worth of quiet
    // to catch anything stray.
    drain_results();
    repeat (40) @(posedge clk);
    if (grid.failures == 0) begin
      $display("life_cellular_automaton_grid test passed");
    end else begin
      $display("life_cellular_automaton_grid test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lca_pkg.sv
sv/lca_row_next.sv
sv/life_cellular_automaton_grid.sv
tb/life_cellular_automaton_grid_tb.sv
